/* design/wsd_pkg.sv */
// Shared types and constants for the weather sensor pulse frame decoder.
package wsd_pkg;

  localparam int unsigned FULL_PAIRS = 52;
  localparam int unsigned HEAD_BITS  = 20;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned NUMER_W    = 22;
  localparam int unsigned RECIP_W    = 23;
  localparam int unsigned PROD_W     = NUMER_W + RECIP_W;

  localparam logic [3:0] PREAMBLE_A = 4'h9;
  localparam logic [3:0] PREAMBLE_B = 4'h6;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MARK_THR  = 2'd0;
  localparam logic [1:0] REG_SPACE_MIN = 2'd1;
  localparam logic [1:0] REG_SPACE_MAX = 2'd2;

  localparam logic [15:0] MARK_THR_RST  = 16'd1000;
  localparam logic [15:0] SPACE_MIN_RST = 16'd1100;
  localparam logic [15:0] SPACE_MAX_RST = 16'd1400;

  // Reciprocals for exact floor division: by 100 and 350 of values below 2**22, by 10 of values below 43690.
  localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;  // 2**29 / 100, rounded up
  localparam logic [RECIP_W-1:0] RECIP_350 = 23'd6135668;  // 2**31 / 350, rounded up
  localparam logic [RECIP_W-1:0] RECIP_10  = 23'd26215;    // 2**18 / 10, rounded up

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_LENGTH   = 3'd1,
    CAUSE_SPACING  = 3'd2,
    CAUSE_HEADER   = 3'd3,
    CAUSE_PREAMBLE = 3'd4,
    CAUSE_CHECKSUM = 3'd5,
    CAUSE_HUMIDITY = 3'd6
  } cause_e;

  typedef enum logic [1:0] {
    KIND_TEMP  = 2'd0,
    KIND_HUMID = 2'd1,
    KIND_RAIN  = 2'd2,
    KIND_WIND  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    DIV_NONE = 2'd0,
    DIV_100  = 2'd1,
    DIV_350  = 2'd2,
    DIV_10   = 2'd3
  } div_e;

  typedef struct packed {
    logic [15:0] mark_thr;
    logic [15:0] space_min;
    logic [15:0] space_max;
  } cfg_t;

  // One finished frame handed from the front to the back.
  typedef struct packed {
    logic [FULL_PAIRS-1:0] bits;
    logic                  len_bad;
    logic                  spacing_bad;
  } frame_rec_t;

  function automatic logic [RECIP_W-1:0] recip_of(div_e sel);
    logic [RECIP_W-1:0] r;
    case (sel)
      DIV_100: r = RECIP_100;
      DIV_350: r = RECIP_350;
      DIV_10:  r = RECIP_10;
      default: r = RECIP_W'(1);
    endcase
    return r;
  endfunction

endpackage

/* design/wsd_front.sv */
// Front end: classifies each pulse pair into a bit and assembles frames.
module wsd_front import wsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [15:0] mark_width_i,
  input  logic [15:0] space_width_i,
  input  logic       last_pair_i,
  output logic       push_valid_o,
  input  logic       push_ready_i,
  output frame_rec_t push_rec_o
);

  logic [FULL_PAIRS-1:0] frame_q, frame_d, frame_next;
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  spacing_bad_q, spacing_bad_d;
  logic                  bit_val, space_bad, accept, short_frame, len_ok;
  logic [CNT_W:0]        total;

  assign in_ready_o   = push_ready_i;
  assign accept       = in_valid_i && push_ready_i;
  assign push_valid_o = in_valid_i && last_pair_i;

  assign bit_val    = (mark_width_i <= cfg_i.mark_thr);
  assign space_bad  = (space_width_i < cfg_i.space_min) || (space_width_i > cfg_i.space_max);
  assign frame_next = {frame_q[FULL_PAIRS-2:0], bit_val};

  assign total       = {1'b0, count_q} + (CNT_W+1)'(1);
  assign short_frame = (total == (CNT_W+1)'(FULL_PAIRS - 1));
  assign len_ok      = short_frame || (total == (CNT_W+1)'(FULL_PAIRS));

  always_comb begin
    // A frame one pair short gets a trailing zero bit.
    push_rec_o.bits        = short_frame ? {frame_next[FULL_PAIRS-2:0], 1'b0} : frame_next;
    push_rec_o.len_bad     = !len_ok;
    push_rec_o.spacing_bad = spacing_bad_q;
  end

  always_comb begin
    frame_d       = frame_q;
    count_d       = count_q;
    spacing_bad_d = spacing_bad_q;
    if (accept) begin
      if (last_pair_i) begin
        frame_d       = '0;
        count_d       = '0;
        spacing_bad_d = 1'b0;
      end else begin
        frame_d       = frame_next;
        spacing_bad_d = spacing_bad_q || space_bad;
        if (count_q != {CNT_W{1'b1}}) begin
          count_d = count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q       <= '0;
      count_q       <= '0;
      spacing_bad_q <= 1'b0;
    end else begin
      frame_q       <= frame_d;
      count_q       <= count_d;
      spacing_bad_q <= spacing_bad_d;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_pair_i) |=> (count_q == '0 && !spacing_bad_q))
    else $error("frame state not cleared after final pair");
`endif

endmodule

/* design/wsd_fifo.sv */
// Short queue of finished frames between the front and the back.
module wsd_fifo import wsd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  frame_rec_t push_rec_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output frame_rec_t pop_rec_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  frame_rec_t        mem_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_rec_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("queue count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + CntW'(1)))
    else $error("queue count lost a push");
`endif

endmodule

/* design/wsd_back.sv */
// Back end: checks a frame, decodes its reading and holds the result item.
module wsd_back import wsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  frame_rec_t        pop_rec_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              frame_ok_o,
  output logic [2:0]        reject_cause_o,
  output logic [1:0]        sensor_kind_o,
  output logic              model_variant_o,
  output logic [7:0]        sensor_id_o,
  output logic signed [15:0] reading_o,
  output logic [3:0]        wind_direction_o
);

  typedef struct packed {
    cause_e              cause;
    kind_e               kind;
    logic                variant;
    logic [7:0]          id;
    logic [3:0]          dir;
    logic [8:0]          offset;
    div_e                div;
  } info_t;

  // Decode stage
  logic [3:0]         d [11];
  logic [3:0]         sum4;
  logic [11:0]        v12;
  logic [7:0]         v8;
  info_t              a_d, a_q;
  logic [NUMER_W-1:0] numer_d, numer_q;
  logic               a_valid_q, a_ready, b_ready;

  // Multiply stage
  info_t              b_q;
  logic [PROD_W-1:0]  prod_q;
  logic               b_valid_q, o_ready;

  // Result register
  logic               out_valid_q;
  cause_e             cause_q;
  kind_e              kind_q;
  logic               variant_q;
  logic [7:0]         id_q;
  logic [15:0]        reading_q, quot;
  logic [3:0]         dir_q;

  assign o_ready     = !out_valid_q || out_ready_i;
  assign b_ready     = !b_valid_q || o_ready;
  assign a_ready     = !a_valid_q || b_ready;
  assign pop_ready_o = a_ready;

  always_comb begin
    for (int i = 0; i < 11; i++) begin
      d[i] = pop_rec_i.bits[FULL_PAIRS - 8 - 4*i +: 4];
    end
    sum4 = '0;
    for (int i = 0; i < 11; i++) begin
      sum4 = sum4 + d[i];
    end
  end

  assign v12 = {d[6], d[7], d[8]};
  assign v8  = {d[6], d[7]};

  always_comb begin
    a_d.cause   = CAUSE_NONE;
    a_d.kind    = kind_e'(d[1][1:0]);
    a_d.variant = (d[0] == PREAMBLE_B);
    a_d.id      = {d[2], d[3]};
    a_d.dir     = '0;
    a_d.offset  = '0;
    a_d.div     = DIV_NONE;
    numer_d     = '0;
    case (a_d.kind)
      KIND_TEMP: begin
        numer_d    = NUMER_W'(d[6]) * NUMER_W'(100) + NUMER_W'(d[7]) * NUMER_W'(10)
                   + NUMER_W'(d[8]);
        a_d.offset = a_d.variant ? 9'd400 : 9'd300;
      end
      KIND_HUMID: begin
        numer_d = NUMER_W'(v8);
        if (v8 == '0) begin
          a_d.cause = CAUSE_HUMIDITY;
        end
      end
      KIND_RAIN: begin
        numer_d = NUMER_W'(v12) * (a_d.variant ? NUMER_W'(518) : NUMER_W'(508));
        a_d.div = a_d.variant ? DIV_100 : DIV_350;
        a_d.id  = {4'h0, d[2]};
      end
      KIND_WIND: begin
        numer_d = NUMER_W'(v8) * NUMER_W'(36);
        a_d.div = a_d.variant ? DIV_NONE : DIV_10;
        a_d.dir = d[8];
      end
      default: begin
        numer_d = '0;
      end
    endcase
    // Earlier checks take priority over the zero humidity reject.
    if (pop_rec_i.len_bad) begin
      a_d.cause = CAUSE_LENGTH;
    end else if (pop_rec_i.spacing_bad) begin
      a_d.cause = CAUSE_SPACING;
    end else if (pop_rec_i.bits[FULL_PAIRS-1 -: HEAD_BITS] == '0) begin
      a_d.cause = CAUSE_HEADER;
    end else if (d[0] != PREAMBLE_A && d[0] != PREAMBLE_B) begin
      a_d.cause = CAUSE_PREAMBLE;
    end else if (sum4 != pop_rec_i.bits[3:0]) begin
      a_d.cause = CAUSE_CHECKSUM;
    end
    // Drop every payload field of a rejected frame.
    if (a_d.cause != CAUSE_NONE) begin
      a_d.kind    = KIND_TEMP;
      a_d.variant = 1'b0;
      a_d.id      = '0;
      a_d.dir     = '0;
      a_d.offset  = '0;
      a_d.div     = DIV_NONE;
      numer_d     = '0;
    end
  end

  always_comb begin
    case (b_q.div)
      DIV_100: quot = prod_q[29 +: 16];
      DIV_350: quot = {2'b00, prod_q[PROD_W-1:31]};
      DIV_10:  quot = prod_q[18 +: 16];
      default: quot = prod_q[15:0];
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= pop_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (o_ready) begin
        out_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && pop_valid_i) begin
      a_q     <= a_d;
      numer_q <= numer_d;
    end
    if (b_ready && a_valid_q) begin
      b_q    <= a_q;
      prod_q <= numer_q * recip_of(a_q.div);
    end
    if (o_ready && b_valid_q) begin
      cause_q   <= b_q.cause;
      kind_q    <= b_q.kind;
      variant_q <= b_q.variant;
      id_q      <= b_q.id;
      dir_q     <= b_q.dir;
      reading_q <= quot - {7'b0, b_q.offset};
    end
  end

  assign out_valid_o      = out_valid_q;
  assign frame_ok_o       = (cause_q == CAUSE_NONE);
  assign reject_cause_o   = cause_q;
  assign sensor_kind_o    = kind_q;
  assign model_variant_o  = variant_q;
  assign sensor_id_o      = id_q;
  assign reading_o        = reading_q;
  assign wind_direction_o = dir_q;

`ifndef ASSERT_OFF
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && cause_q != CAUSE_NONE) |->
      (reading_q == '0 && id_q == '0 && dir_q == '0 && kind_q == KIND_TEMP && !variant_q))
    else $error("rejected item carries payload");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != KIND_WIND) |-> (dir_q == '0))
    else $error("direction set on a non-wind item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && !b_ready) |=> a_valid_q)
    else $error("decode stage lost an item under stall");
`endif

endmodule

/* design/weather_sensor_pulse_frame_decoder_top.sv */
// Top level: configuration registers and the front, queue and back of the decoder.
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one mark/space pulse pair per item;
//   last_pair_i closes a frame. Each closing pair yields exactly one result item on
//   the output channel (out_valid_o/out_ready_i), decoded or rejected with a cause.
//   Non-final pairs yield no item.
//   Throughput: one pair per cycle while the frame queue is not full. A result
//   passes the queue, decode stage, multiply stage and result register.
//   The rate is set by the decode pipeline feeding one reciprocal multiplier.
//   When the receiver stalls, results back up through the pipeline into the
//   frame queue (QUEUE_DEPTH entries); in_ready_o falls only when that queue is
//   full, so non-final pairs keep flowing until then.
//   Reset clears the partial frame, the pipeline and the queue, and loads the
//   thresholds with 1000, 1100 and 1400 ticks.
//   Registers sit at byte addresses 0 (mark threshold), 4 (space min) and
//   8 (space max); write them only while the block is idle.
module weather_sensor_pulse_frame_decoder_top import wsd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        mark_width_i,
  input  logic [15:0]        space_width_i,
  input  logic               last_pair_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_ok_o,
  output logic [2:0]         reject_cause_o,
  output logic [1:0]         sensor_kind_o,
  output logic               model_variant_o,
  output logic [7:0]         sensor_id_o,
  output logic signed [15:0] reading_o,
  output logic [3:0]         wind_direction_o
);

  cfg_t       cfg_q, cfg_d;
  logic       cfg_wr;
  logic [1:0] reg_idx;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  frame_rec_t push_rec, pop_rec;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (reg_idx)
        REG_MARK_THR:  cfg_d.mark_thr  = pwdata[15:0];
        REG_SPACE_MIN: cfg_d.space_min = pwdata[15:0];
        REG_SPACE_MAX: cfg_d.space_max = pwdata[15:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MARK_THR:  prdata = {16'h0, cfg_q.mark_thr};
      REG_SPACE_MIN: prdata = {16'h0, cfg_q.space_min};
      REG_SPACE_MAX: prdata = {16'h0, cfg_q.space_max};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mark_thr  <= MARK_THR_RST;
      cfg_q.space_min <= SPACE_MIN_RST;
      cfg_q.space_max <= SPACE_MAX_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mark_width_i (mark_width_i),
    .space_width_i(space_width_i),
    .last_pair_i  (last_pair_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_rec_o   (push_rec)
  );

  wsd_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_rec_i  (push_rec),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_rec_o   (pop_rec)
  );

  wsd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_ready_o     (pop_ready),
    .pop_rec_i       (pop_rec),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_ok_o      (frame_ok_o),
    .reject_cause_o  (reject_cause_o),
    .sensor_kind_o   (sensor_kind_o),
    .model_variant_o (model_variant_o),
    .sensor_id_o     (sensor_id_o),
    .reading_o       (reading_o),
    .wind_direction_o(wind_direction_o)
  );

endmodule

/* tb/sv/tb.sv */
// Testbench for the pulse frame decoder: random frames, self-checking predictor.
`timescale 1ns / 1ps

module tb;
  import wsd_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned NUM_PHASES  = 8;

  typedef struct packed {
    logic [15:0] mark;
    logic [15:0] space;
    logic        last;
  } pulse_pair_t;

  typedef struct packed {
    logic        ok;
    cause_e      cause;
    kind_e       kind;
    logic        variant;
    logic [7:0]  id;
    logic [15:0] reading;
    logic [3:0]  dir;
  } frame_res_t;

  typedef enum int {
    FR_TEMP, FR_HUMID, FR_RAIN, FR_WIND, FR_HUMID_ZERO, FR_SHORT, FR_BAD_LEN,
    FR_BAD_SPACE, FR_ZERO_HEAD, FR_BAD_PRE, FR_BAD_SUM, FR_NOISE, FR_COUNT
  } frame_case_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] mark_width_i = '0;
  logic [15:0] space_width_i = '0;
  logic        last_pair_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        frame_ok_o;
  logic [2:0]  reject_cause_o;
  logic [1:0]  sensor_kind_o;
  logic        model_variant_o;
  logic [7:0]  sensor_id_o;
  logic signed [15:0] reading_o;
  logic [3:0]  wind_direction_o;

  weather_sensor_pulse_frame_decoder_top i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .mark_width_i, .space_width_i, .last_pair_i,
    .out_valid_o, .out_ready_i, .frame_ok_o, .reject_cause_o, .sensor_kind_o,
    .model_variant_o, .sensor_id_o, .reading_o, .wind_direction_o
  );

  // Decoder state mirror and register copies
  logic [FULL_PAIRS-1:0] frame_acc = '0;
  logic [5:0]            pair_cnt = '0;
  logic                  spacing_err = 1'b0;
  logic [15:0]           mark_thr = MARK_THR_RST;
  logic [15:0]           space_lo = SPACE_MIN_RST;
  logic [15:0]           space_hi = SPACE_MAX_RST;

  pulse_pair_t pair_q[$];
  frame_res_t  decoded_q[$];
  int unsigned pairs_queued = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  logic        in_took = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Shift one pair into the mirrored frame; on the closing pair, decode it.
  function automatic void predict_pair(input logic [15:0] mark, input logic [15:0] space,
                                       input logic last);
    frame_res_t            r;
    logic [FULL_PAIRS-1:0] f;
    int                    d[11];
    int                    total;
    int                    val;
    int                    rd;
    logic [3:0]            nib_sum;
    cause_e                c;
    r = '0;
    rd = 0;
    frame_acc = {frame_acc[FULL_PAIRS-2:0], (mark <= mark_thr)};
    if (!last) begin
      if (space < space_lo || space > space_hi) spacing_err = 1'b1;
      if (pair_cnt != 6'd63) pair_cnt = pair_cnt + 6'd1;
      return;
    end
    total = int'(pair_cnt) + 1;
    f = frame_acc;
    // short frame gets a trailing zero bit
    if (total == FULL_PAIRS - 1) f = f << 1;
    nib_sum = '0;
    for (int i = 0; i < 11; i++) begin
      d[i] = int'(f[44 - 4 * i +: 4]);
      nib_sum = nib_sum + 4'(d[i]);
    end
    r.cause = CAUSE_NONE;
    if (total != FULL_PAIRS && total != FULL_PAIRS - 1) r.cause = CAUSE_LENGTH;
    else if (spacing_err) r.cause = CAUSE_SPACING;
    else if (f[FULL_PAIRS-1 -: HEAD_BITS] == '0) r.cause = CAUSE_HEADER;
    else if (d[0] != int'(PREAMBLE_A) && d[0] != int'(PREAMBLE_B)) r.cause = CAUSE_PREAMBLE;
    else if (nib_sum != f[3:0]) r.cause = CAUSE_CHECKSUM;
    else begin
      r.kind = kind_e'(2'(d[1]));
      r.variant = (d[0] == int'(PREAMBLE_B));
      r.id = 8'(d[2] * 16 + d[3]);
      case (r.kind)
        KIND_TEMP: begin
          rd = d[6] * 100 + d[7] * 10 + d[8] - (r.variant ? 400 : 300);
        end
        KIND_HUMID: begin
          rd = d[6] * 16 + d[7];
          if (rd == 0) r.cause = CAUSE_HUMIDITY;
        end
        KIND_RAIN: begin
          val = d[6] * 256 + d[7] * 16 + d[8];
          rd = r.variant ? (val * 518) / 100 : (val * 508) / 350;
          r.id = 8'(d[2]);
        end
        default: begin
          rd = (d[6] * 16 + d[7]) * 36;
          if (!r.variant) rd = rd / 10;
          r.dir = 4'(d[8]);
        end
      endcase
      r.reading = 16'(rd);
    end
    frame_acc = '0;
    pair_cnt = '0;
    spacing_err = 1'b0;
    if (r.cause != CAUSE_NONE) begin
      c = r.cause;
      r = '0;
      r.cause = c;
    end
    r.ok = (r.cause == CAUSE_NONE);
    decoded_q.push_back(r);
  endfunction

  function automatic logic [15:0] mark_for(input logic one);
    if (one) return 16'($urandom_range(mark_thr, 0));
    if (mark_thr == 16'hffff) return 16'hffff;
    return 16'($urandom_range(65535, int'(mark_thr) + 1));
  endfunction

  function automatic logic [15:0] space_in_window();
    if (space_lo <= space_hi) return 16'($urandom_range(space_hi, space_lo));
    return 16'($urandom_range(65535, 0));
  endfunction

  function automatic void queue_pair(input logic [15:0] mark, input logic [15:0] space,
                                     input logic last);
    pair_q.push_back('{mark: mark, space: space, last: last});
    pairs_queued++;
  endfunction

  // Build one frame of the given flavor and queue its pulse pairs.
  function automatic void queue_frame(input frame_case_e fc);
    logic [3:0]            nb[13];
    logic [FULL_PAIRS-1:0] f;
    logic [3:0]            nib_sum;
    logic [15:0]           sp;
    int                    len;
    int                    bad_at;
    int                    n;
    if (fc == FR_NOISE) begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++) begin
        queue_pair(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                   (i == n - 1) ? ($urandom_range(7, 0) != 0) : ($urandom_range(15, 0) == 0));
      end
      return;
    end
    nb[0] = 4'($urandom_range(15, 0));
    nb[1] = $urandom_range(1, 0) ? PREAMBLE_B : PREAMBLE_A;
    for (int i = 2; i < 12; i++) nb[i] = 4'($urandom_range(15, 0));
    case (fc)
      FR_TEMP:  nb[2][1:0] = KIND_TEMP;
      FR_HUMID: nb[2][1:0] = KIND_HUMID;
      FR_RAIN:  nb[2][1:0] = KIND_RAIN;
      FR_WIND:  nb[2][1:0] = KIND_WIND;
      FR_HUMID_ZERO: begin
        nb[2][1:0] = KIND_HUMID;
        nb[7] = '0;
        nb[8] = '0;
      end
      FR_ZERO_HEAD: begin
        for (int i = 0; i < 5; i++) nb[i] = '0;
      end
      FR_BAD_PRE: begin
        while (nb[1] == PREAMBLE_A || nb[1] == PREAMBLE_B) nb[1] = 4'($urandom_range(15, 0));
      end
      default: ;
    endcase
    nib_sum = '0;
    for (int i = 1; i < 12; i++) nib_sum = nib_sum + nb[i];
    nb[12] = nib_sum;
    if (fc == FR_BAD_SUM) nb[12] = nib_sum + 4'($urandom_range(15, 1));
    len = FULL_PAIRS;
    if (fc == FR_SHORT) begin
      len = FULL_PAIRS - 1;
      // dropped last bit reads as zero: make the checksum even
      if (nb[12][0]) begin
        nb[11] = nb[11] + 4'd1;
        nb[12] = nb[12] + 4'd1;
      end
    end
    if (fc == FR_BAD_LEN) begin
      len = ($urandom_range(2, 0) == 0) ? $urandom_range(80, FULL_PAIRS + 1)
                                        : $urandom_range(FULL_PAIRS - 2, 1);
    end
    bad_at = (fc == FR_BAD_SPACE) ? $urandom_range(len - 2, 0) : -1;
    for (int i = 0; i < 13; i++) f[FULL_PAIRS - 1 - 4 * i -: 4] = nb[i];
    for (int i = 0; i < len; i++) begin
      sp = space_in_window();
      if (i == len - 1) sp = 16'($urandom_range(65535, 0));
      else if (i == bad_at) begin
        if (space_lo > 0) sp = 16'($urandom_range(int'(space_lo) - 1, 0));
        else if (space_hi < 16'hffff) sp = 16'($urandom_range(65535, int'(space_hi) + 1));
      end
      queue_pair(mark_for((i < FULL_PAIRS) ? f[FULL_PAIRS - 1 - i] : 1'($urandom_range(1, 0))),
                 sp, (i == len - 1));
    end
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0, value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MARK_THR:  mark_thr = value;
      REG_SPACE_MIN: space_lo = value;
      REG_SPACE_MAX: space_hi = value;
      default: ;
    endcase
  endtask

  task automatic write_cfg(input logic [15:0] thr, input logic [15:0] lo, input logic [15:0] hi);
    write_reg(REG_MARK_THR, thr);
    write_reg(REG_SPACE_MIN, lo);
    write_reg(REG_SPACE_MAX, hi);
  endtask

  // Wait until every queued pair is in and every frame result is out.
  task automatic drain();
    while (pair_q.size() != 0 || in_valid_i || decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Pair driver and result-ready generator
  always @(negedge clk_i) begin : drive_pairs
    pulse_pair_t p;
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (pair_q.size() != 0 && $urandom_range(99, 0) >= src_idle_pct) begin
          p = pair_q.pop_front();
          in_valid_i    <= 1'b1;
          mark_width_i  <= p.mark;
          space_width_i <= p.space;
          last_pair_i   <= p.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99, 0) >= sink_stall_pct);
    end
  end

  // Monitor: predict on accepted pairs, check accepted results, watch for hangs.
  always @(posedge clk_i) begin : watch_ports
    frame_res_t want;
    frame_res_t got;
    logic       out_took;
    in_took  = rst_ni && in_valid_i && in_ready_o;
    out_took = rst_ni && out_valid_o && out_ready_i;
    if (in_took) predict_pair(mark_width_i, space_width_i, last_pair_i);
    if (out_took) begin
      got.ok      = frame_ok_o;
      got.cause   = cause_e'(reject_cause_o);
      got.kind    = kind_e'(sensor_kind_o);
      got.variant = model_variant_o;
      got.id      = sensor_id_o;
      got.reading = reading_o;
      got.dir     = wind_direction_o;
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result ok=%0b cause=%0d", $realtime, got.ok, got.cause);
      end else begin
        want = decoded_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: result mismatch", $realtime);
            $display("  expected ok=%0b cause=%0d kind=%0d var=%0b id=%02h reading=%0d dir=%0d",
                     want.ok, want.cause, want.kind, want.variant, want.id,
                     $signed(want.reading), want.dir);
            $display("  actual   ok=%0b cause=%0d kind=%0d var=%0b id=%02h reading=%0d dir=%0d",
                     got.ok, got.cause, got.kind, got.variant, got.id,
                     $signed(got.reading), got.dir);
          end
        end
      end
    end
    if (in_took || out_took || psel) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned start_cnt;
    int unsigned budget;
    int          k;
    int          r;
    frame_case_e fc;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 53; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 53; end
        default: begin src_idle_pct = 34; sink_stall_pct = 34; end
      endcase
      case (ph)
        1: begin
          r = $urandom_range(2000, 0);
          write_cfg(16'($urandom_range(3000, 200)), 16'(r), 16'(r + $urandom_range(3000, 0)));
        end
        2: write_cfg(16'h0000, 16'h0000, 16'hffff);
        3: write_cfg(16'hffff, 16'hffff, 16'hffff);
        4: write_cfg(16'd500, 16'd2000, 16'd1000);  // empty spacing window
        5: write_cfg(MARK_THR_RST, SPACE_MIN_RST, SPACE_MAX_RST);
        6: write_cfg(16'hfffe, 16'h0000, 16'h0000);
        7: write_cfg(16'($urandom_range(65535, 0)), 16'($urandom_range(65535, 0)),
                     16'($urandom_range(65535, 0)));
        default: ;
      endcase
      start_cnt = pairs_queued;
      if (ph == 0) begin
        // single-pair and odd frames around the field and threshold edges
        queue_pair(16'h0000, 16'h0000, 1'b1);
        queue_pair(16'hffff, 16'hffff, 1'b1);
        queue_pair(MARK_THR_RST, SPACE_MIN_RST, 1'b0);
        queue_pair(MARK_THR_RST + 16'd1, SPACE_MAX_RST, 1'b0);
        queue_pair(MARK_THR_RST, SPACE_MIN_RST - 16'd1, 1'b0);
        queue_pair(MARK_THR_RST + 16'd1, SPACE_MAX_RST + 16'd1, 1'b0);
        queue_pair(16'h0000, 16'hffff, 1'b1);
        queue_pair(16'hffff, 16'h0000, 1'b0);
        queue_pair(16'h5555, 16'haaaa, 1'b1);
        queue_pair(16'haaaa, 16'h5555, 1'b1);
      end
      budget = (ph == 0) ? 650 : 150;
      k = 0;
      while (pairs_queued - start_cnt < budget) begin
        if (ph == 0 && k < int'(FR_COUNT)) fc = frame_case_e'(k);
        else begin
          r = $urandom_range(99, 0);
          if (r < 55) fc = frame_case_e'($urandom_range(int'(FR_WIND), int'(FR_TEMP)));
          else if (r < 65) fc = FR_SHORT;
          else if (r < 70) fc = FR_HUMID_ZERO;
          else if (r < 76) fc = FR_BAD_LEN;
          else if (r < 82) fc = FR_BAD_SPACE;
          else if (r < 86) fc = FR_ZERO_HEAD;
          else if (r < 90) fc = FR_BAD_PRE;
          else if (r < 95) fc = FR_BAD_SUM;
          else fc = FR_NOISE;
        end
        queue_frame(fc);
        k++;
      end
      drain();
    end
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && decoded_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
